@@ rtl/tfb_pkg.sv @@
package tfb_pkg;

	localparam int unsigned FRAME_LEN = 25;
	localparam int unsigned CRC_SPAN  = 24;

	localparam logic [7:0]  SYNC_A      = 8'hA5;
	localparam logic [7:0]  SYNC_B      = 8'hEC;
	localparam logic [7:0]  CRC_POLY    = 8'h07;
	localparam logic [31:0] TICKS_RESET = 32'd16800000;

	// byte position within a frame, 0 .. FRAME_LEN-1
	typedef logic [4:0] tfb_byte_idx_t;

	localparam tfb_byte_idx_t CRC_POS = tfb_byte_idx_t'(CRC_SPAN);

	// frame bytes 0 .. 23, byte n in element n
	typedef logic [CRC_SPAN-1:0][7:0] tfb_frame_t;

	// serializer activity, seen by the top level
	typedef struct packed {
		logic load;  // a byte enters the output register
		logic last;  // that byte is the CRC byte
	} tfb_back_stat_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/tfb_channels.sv @@
interface tfb_payload_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] pos_north;
	logic signed [15:0] pos_east;
	logic signed [15:0] pos_down;
	logic signed [15:0] vel_vertical;
	logic signed [15:0] acc_vertical;
	logic signed [15:0] quat_w0;
	logic signed [15:0] quat_w1;
	logic signed [15:0] quat_w2;
	logic signed [15:0] quat_w3;
	logic [2:0]         flight_mode;
	logic [2:0]         sensor_code;
	logic [1:0]         eject_code;

	modport source (
		output valid, pos_north, pos_east, pos_down, vel_vertical, acc_vertical,
		       quat_w0, quat_w1, quat_w2, quat_w3, flight_mode, sensor_code, eject_code,
		input  ready
	);
	modport sink (
		input  valid, pos_north, pos_east, pos_down, vel_vertical, acc_vertical,
		       quat_w0, quat_w1, quat_w2, quat_w3, flight_mode, sensor_code, eject_code,
		output ready
	);
endinterface

interface tfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, frame_byte, frame_last, input ready);
	modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

@@ rtl/tfb_front.sv @@
module tfb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [31:0]         cfg_wr_data,
	tfb_payload_if.sink         payload,
	output logic                push,
	input  logic                push_ready,
	output tfb_pkg::tfb_frame_t push_frame
);
	import tfb_pkg::*;

	logic [31:0] ticks_q;
	logic [31:0] accum_q;
	logic [3:0]  seq_q;
	logic [31:0] accum_sum;

	assign payload.ready = push_ready;
	assign push          = payload.valid && push_ready;
	assign accum_sum     = accum_q + ticks_q;

	always_comb begin
		push_frame[0]  = SYNC_A;
		push_frame[1]  = SYNC_B;
		push_frame[2]  = accum_sum[23:16];
		push_frame[3]  = accum_sum[31:24];
		push_frame[4]  = payload.pos_north[7:0];
		push_frame[5]  = payload.pos_north[15:8];
		push_frame[6]  = payload.pos_east[7:0];
		push_frame[7]  = payload.pos_east[15:8];
		push_frame[8]  = payload.pos_down[7:0];
		push_frame[9]  = payload.pos_down[15:8];
		push_frame[10] = payload.vel_vertical[7:0];
		push_frame[11] = payload.vel_vertical[15:8];
		push_frame[12] = payload.acc_vertical[7:0];
		push_frame[13] = payload.acc_vertical[15:8];
		push_frame[14] = payload.quat_w0[7:0];
		push_frame[15] = payload.quat_w0[15:8];
		push_frame[16] = payload.quat_w1[7:0];
		push_frame[17] = payload.quat_w1[15:8];
		push_frame[18] = payload.quat_w2[7:0];
		push_frame[19] = payload.quat_w2[15:8];
		push_frame[20] = payload.quat_w3[7:0];
		push_frame[21] = payload.quat_w3[15:8];
		push_frame[22] = {payload.eject_code, payload.sensor_code, payload.flight_mode};
		push_frame[23] = {seq_q, seq_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
		end else if (cfg_wr_en) begin
			ticks_q <= cfg_wr_data;
		end
	end

	// advance timestamp and sequence once per accepted payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			seq_q   <= '0;
		end else if (push) begin
			accum_q <= accum_sum;
			seq_q   <= seq_q + 4'd1;
		end
	end

endmodule

@@ rtl/tfb_queue.sv @@
module tfb_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                push_ready,
	input  tfb_pkg::tfb_frame_t push_frame,
	input  logic                pop,
	output logic                pop_valid,
	output tfb_pkg::tfb_frame_t pop_frame
);
	import tfb_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	tfb_frame_t     entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_frame  = entry_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/tfb_back.sv @@
module tfb_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	input  tfb_pkg::tfb_frame_t    pop_frame,
	output logic                   pop,
	tfb_byte_if.source             frame,
	output tfb_pkg::tfb_back_stat_t stat
);
	import tfb_pkg::*;

	tfb_byte_idx_t idx_q;
	logic [7:0]    crc_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;

	logic          adv;
	logic          load;
	logic          at_crc;
	logic [7:0]    cur_byte;
	logic [7:0]    crc_base;

	assign adv      = !out_valid_q || frame.ready;
	assign load     = adv && pop_valid;
	assign at_crc   = (idx_q == CRC_POS);
	assign cur_byte = at_crc ? crc_q : pop_frame[idx_q];
	assign crc_base = (idx_q == '0) ? 8'h00 : crc_q;
	assign pop      = load && at_crc;

	assign stat.load = load;
	assign stat.last = at_crc;

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = out_byte_q;
	assign frame.frame_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			if (at_crc) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + tfb_byte_idx_t'(1);
				crc_q <= crc8_step(crc_base, cur_byte);
			end
		end else if (adv) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= cur_byte;
			out_last_q <= at_crc;
		end
	end

endmodule

@@ rtl/telemetry_frame_builder.sv @@
// Telemetry frame builder. Each accepted payload becomes one 25-byte frame on the
// frame channel: sync A5 EC, a 16-bit timestamp (upper half of a wrapping 16.16
// accumulator that gains the configured tick step per payload), the nine 16-bit words
// little-endian, the packed code byte, a doubled 4-bit sequence byte and a CRC-8
// (poly 07, init 00) over bytes 0..23, flagged by frame_last. Bytes leave one per
// cycle from an output register while the receiver is ready, so the sustained
// payload rate is set by the byte serializer. Payloads are taken at once while the
// frame queue (QUEUE_DEPTH entries) has room; an accepted payload is registered into
// the queue, from which its bytes are loaded into the output register. Write the
// tick step only while no frame is in flight.
module telemetry_frame_builder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	tfb_payload_if.sink payload,
	tfb_byte_if.source  frame
);
	import tfb_pkg::*;

	logic           q_push;
	logic           q_ready;
	tfb_frame_t     q_in_frame;
	logic           q_pop;
	logic           q_valid;
	tfb_frame_t     q_out_frame;
	tfb_back_stat_t back_stat;

	tfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.payload    (payload),
		.push       (q_push),
		.push_ready (q_ready),
		.push_frame (q_in_frame)
	);

	tfb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_ready(q_ready),
		.push_frame(q_in_frame),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_frame (q_out_frame)
	);

	tfb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(q_valid),
		.pop_frame(q_out_frame),
		.pop      (q_pop),
		.frame    (frame),
		.stat     (back_stat)
	);

`ifndef SYNTH
	// release a queued frame only with its CRC byte
	a_pop_on_crc: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && back_stat.load && back_stat.last))
		else $error("frame released without its CRC byte");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_ready)
		else $error("payload taken into a full queue");

	// the CRC byte loaded into the output register shows as last next cycle
	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(back_stat.load && back_stat.last) |=> (frame.valid && frame.frame_last))
		else $error("CRC byte not flagged last");
`endif

endmodule

@@ bench/tfb_frame_checker.sv @@
module tfb_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	tfb_payload_if      payload,
	tfb_byte_if         frame,
	output int unsigned mismatches,
	output int unsigned bytes_pending,
	output int unsigned bytes_checked,
	output int unsigned frames_done
);
	import tfb_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic [31:0]  tick_step;
	logic [31:0]  stamp_accum;
	logic [3:0]   seq_num;
	frame_byte_t  expected_bytes[$];

	// Bitwise CRC-8, MSB first, no reflection.
	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] din);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int b = 7; b >= 0; b--) begin
			fb = r[7] ^ din[b];
			r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	function automatic void predict_frame();
		logic [7:0]       fbytes[FRAME_LEN];
		logic [8:0][15:0] words;
		logic [7:0]       crc;
		frame_byte_t      entry;
		words = {payload.quat_w3, payload.quat_w2, payload.quat_w1, payload.quat_w0,
			payload.acc_vertical, payload.vel_vertical, payload.pos_down,
			payload.pos_east, payload.pos_north};
		stamp_accum = stamp_accum + tick_step;
		fbytes[0] = SYNC_A;
		fbytes[1] = SYNC_B;
		fbytes[2] = stamp_accum[23:16];
		fbytes[3] = stamp_accum[31:24];
		for (int i = 0; i < 9; i++) begin
			fbytes[4 + 2 * i] = words[i][7:0];
			fbytes[5 + 2 * i] = words[i][15:8];
		end
		fbytes[22] = {payload.eject_code, payload.sensor_code, payload.flight_mode};
		fbytes[23] = {seq_num, seq_num};
		seq_num    = seq_num + 4'd1;
		crc = 8'h00;
		for (int i = 0; i < CRC_SPAN; i++) begin
			crc = crc8_fold(crc, fbytes[i]);
		end
		fbytes[CRC_SPAN] = crc;
		for (int i = 0; i < FRAME_LEN; i++) begin
			entry.data = fbytes[i];
			entry.last = (i == FRAME_LEN - 1);
			expected_bytes.push_back(entry);
		end
	endfunction

	function automatic void check_word();
		frame_byte_t want;
		if (expected_bytes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("ERROR: unexpected frame word data=%02h last=%0b",
					frame.frame_byte, frame.frame_last);
			end
			return;
		end
		want = expected_bytes.pop_front();
		bytes_checked++;
		if (want.last) begin
			frames_done++;
		end
		if (frame.frame_byte !== want.data || frame.frame_last !== want.last) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("ERROR: frame word %0d: expected data=%02h last=%0b, got data=%02h last=%0b",
					bytes_checked - 1, want.data, want.last, frame.frame_byte, frame.frame_last);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step     = TICKS_RESET;
			stamp_accum   = '0;
			seq_num       = '0;
			expected_bytes.delete();
			mismatches    = 0;
			bytes_pending = 0;
			bytes_checked = 0;
			frames_done   = 0;
		end else begin
			if (cfg_wr_en) begin
				tick_step = cfg_wr_data;
			end
			if (payload.valid && payload.ready) begin
				predict_frame();
			end
			if (frame.valid && frame.ready) begin
				check_word();
			end
			bytes_pending = expected_bytes.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
	import tfb_pkg::*;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [31:0] cfg_wr_data = '0;

	int unsigned mismatches;
	int unsigned bytes_pending;
	int unsigned bytes_checked;
	int unsigned frames_done;
	int unsigned payloads_sent  = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned holdoff_cycles = 0;
	int unsigned tick_settings  = 0;

	tfb_payload_if payload();
	tfb_byte_if    frame();

	telemetry_frame_builder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.payload     (payload),
		.frame       (frame)
	);

	tfb_frame_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.payload       (payload),
		.frame         (frame),
		.mismatches    (mismatches),
		.bytes_pending (bytes_pending),
		.bytes_checked (bytes_checked),
		.frames_done   (frames_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#3200000;
		$display("Test completed with failures");
		$finish;
	end

	// Frame receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		frame.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_cycles > 0) begin
				holdoff_cycles--;
				frame.ready <= 1'b0;
			end else begin
				frame.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_payload(input logic [8:0][15:0] words, input logic [2:0] fm,
			input logic [2:0] sc, input logic [1:0] ec);
		while ($urandom_range(99) < send_idle_pct) begin
			payload.valid <= 1'b0;
			@(negedge clk);
		end
		payload.valid        <= 1'b1;
		payload.pos_north    <= words[0];
		payload.pos_east     <= words[1];
		payload.pos_down     <= words[2];
		payload.vel_vertical <= words[3];
		payload.acc_vertical <= words[4];
		payload.quat_w0      <= words[5];
		payload.quat_w1      <= words[6];
		payload.quat_w2      <= words[7];
		payload.quat_w3      <= words[8];
		payload.flight_mode  <= fm;
		payload.sensor_code  <= sc;
		payload.eject_code   <= ec;
		@(posedge clk);
		while (!payload.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		payloads_sent++;
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(15))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random_payload();
		logic [8:0][15:0] words;
		for (int i = 0; i < 9; i++) begin
			words[i] = pick_word();
		end
		send_payload(words, 3'($urandom_range(7)), 3'($urandom_range(7)),
			2'($urandom_range(3)));
	endtask

	// Hold the payload channel quiet until every expected word has arrived.
	task automatic wait_drained();
		payload.valid <= 1'b0;
		while (bytes_pending != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_ticks(input logic [31:0] value);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		tick_settings++;
	endtask

	task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input logic [31:0] ticks, input int unsigned count, input int unsigned holdoff,
			input int unsigned pause_at);
		write_ticks(ticks);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		holdoff_cycles = holdoff;
		for (int unsigned n = 0; n < count; n++) begin
			if (pause_at != 0 && n == pause_at) begin
				wait_drained();
			end
			send_random_payload();
		end
	endtask

	initial begin
		logic [8:0][15:0] words;
		payload.valid        = 1'b0;
		payload.pos_north    = '0;
		payload.pos_east     = '0;
		payload.pos_down     = '0;
		payload.vel_vertical = '0;
		payload.acc_vertical = '0;
		payload.quat_w0      = '0;
		payload.quat_w1      = '0;
		payload.quat_w2      = '0;
		payload.quat_w3      = '0;
		payload.flight_mode  = '0;
		payload.sensor_code  = '0;
		payload.eject_code   = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Field extremes and bit patterns with the reset tick step.
		send_payload({9{16'h0000}}, 3'd0, 3'd0, 2'd0);
		send_payload({9{16'hFFFF}}, 3'd7, 3'd7, 2'd3);
		send_payload({9{16'h7FFF}}, 3'd5, 3'd2, 2'd1);
		send_payload({9{16'h8000}}, 3'd2, 3'd5, 2'd2);
		send_payload({9{16'h5555}}, 3'd5, 3'd5, 2'd1);
		send_payload({9{16'hAAAA}}, 3'd2, 3'd2, 2'd2);
		// Walk every code value.
		for (int i = 0; i < 8; i++) begin
			for (int k = 0; k < 9; k++) begin
				words[k] = 16'($urandom);
			end
			send_payload(words, 3'(i), 3'(7 - i), 2'(i));
		end

		// Largest step wraps the accumulator every frame.
		write_ticks(32'hFFFF_FFFF);
		repeat (4) send_random_payload();
		// Zero step repeats the timestamp.
		write_ticks(32'h0000_0000);
		repeat (3) send_random_payload();
		write_ticks(32'h0000_0001);
		repeat (2) send_random_payload();

		run_phase(0, 0, 32'h0001_0000, 90, 0, 0);
		run_phase(69, 0, $urandom, 90, 0, 45);
		// Long receiver hold-off while payloads keep coming fills the frame queue.
		run_phase(0, 69, TICKS_RESET, 90, 400, 0);
		run_phase(14, 14, 32'h7FFF_FFFF, 100, 0, 0);

		wait_drained();
		repeat (60) @(negedge clk);
		$display("Summary: %0d payloads sent, %0d frames (%0d words) checked", payloads_sent,
			frames_done, bytes_checked);
		$display("  over %0d tick settings incl. zero and full-scale steps, four handshake mixes",
			tick_settings);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
